/* rtl/dwcpi_pkg.sv */
// Shared package for the dual wheel cascaded PI speed controller.
// Holds field widths, configuration register indexes, reset values and the config struct.
// No dependencies.
package dwcpi_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int COUNT_W    = 10;
    localparam int SUM_W      = 16;
    localparam int CORR_W     = 16;
    localparam int DRIVE_W    = 24;
    localparam int TICK_W     = 6;
    localparam int PERIOD_W   = 8;
    localparam int INNER_G_W  = 20;
    localparam int OUTER_G_W  = 18;
    localparam int TARGET_W   = 10;
    localparam int WINDOW_W   = 10;
    localparam int INNER_FRAC = 8;
    localparam int OUTER_FRAC = 16;
    localparam int DIFF_ERR_W = SUM_W + 1;
    localparam int WHEEL_ERR_W = SUM_W + 3;

    localparam logic [CFG_IDX_W-1:0] REG_INNER_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_I   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_P   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_I   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PERIODS   = 3'd7;

    localparam logic [INNER_G_W-1:0] RST_INNER_P = 20'd230605;
    localparam logic [INNER_G_W-1:0] RST_INNER_I = 20'd221184;
    localparam logic [OUTER_G_W-1:0] RST_OUTER_P = 18'd34452;
    localparam logic [OUTER_G_W-1:0] RST_OUTER_I = 18'd32054;
    localparam logic [TARGET_W-1:0]  RST_TARGET  = 10'd35;
    localparam logic [WINDOW_W-1:0]  RST_WINDOW  = 10'd5;
    localparam logic [TICK_W-1:0]    RST_TICKS   = 6'd20;
    localparam logic [PERIOD_W-1:0]  RST_PERIODS = 8'd80;

    typedef struct packed {
        logic [INNER_G_W-1:0] inner_p;
        logic [INNER_G_W-1:0] inner_i;
        logic [OUTER_G_W-1:0] outer_p;
        logic [OUTER_G_W-1:0] outer_i;
        logic [TARGET_W-1:0]  target;
        logic [WINDOW_W-1:0]  window;
        logic [TICK_W-1:0]    ticks;
        logic [PERIOD_W-1:0]  periods;
    } t_cfg;

endpackage

/* rtl/dual_wheel_cascaded_pi_speed.sv */
// Dual wheel cascaded PI speed controller: each item is one tick of left and right
// encoder counts; one item of held left/right drives is returned per input item. The
// path is an input register, a single combinational pass (accumulate, three PI terms
// with six multipliers in parallel, truncate, saturate, state update) and an output
// register, so one item is accepted every clock cycle while the output side does not
// stall; an accepted item is held in the input register, goes through the combinational
// pass and its result is presented from the output register. The correction and drive
// state closes its loop through that one combinational pass, which sets the clock limit.
// Depends on dwcpi_pkg, dwcpi_cfg_regs and dwcpi_pi_term.
module dual_wheel_cascaded_pi_speed
    import dwcpi_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [COUNT_W-1:0] i_left_count,
    input  logic signed [COUNT_W-1:0] i_right_count,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [DRIVE_W-1:0] o_left_drive,
    output logic signed [DRIVE_W-1:0] o_right_drive
);

    t_cfg cfg;

    dwcpi_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // input register
    logic                      r_in_valid;
    logic signed [COUNT_W-1:0] r_left_count;
    logic signed [COUNT_W-1:0] r_right_count;

    // controller state
    logic [TICK_W-1:0]         r_tick;
    logic [PERIOD_W-1:0]       r_period;
    logic signed [SUM_W-1:0]   r_lsum;
    logic signed [SUM_W-1:0]   r_rsum;
    logic signed [CORR_W-1:0]  r_u;
    logic signed [DRIVE_W-1:0] r_lhold;
    logic signed [DRIVE_W-1:0] r_rhold;

    // output register
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_left_drive;
    logic signed [DRIVE_W-1:0] r_right_drive;

    logic advance;
    logic in_take;

    logic [TICK_W-1:0]         tick_a;
    logic signed [SUM_W-1:0]   lsum_a;
    logic signed [SUM_W-1:0]   rsum_a;
    logic                      upd;
    logic [PERIOD_W-1:0]       period_a;
    logic                      zero;
    logic signed [DIFF_ERR_W-1:0]  e_diff;
    logic signed [WHEEL_ERR_W-1:0] e_left;
    logic signed [WHEEL_ERR_W-1:0] e_right;
    logic signed [WHEEL_ERR_W-1:0] tgt_x;
    logic signed [WHEEL_ERR_W-1:0] u_x;
    logic signed [CORR_W-1:0]  u_new;
    logic signed [DRIVE_W-1:0] ldrv_new;
    logic signed [DRIVE_W-1:0] rdrv_new;

    logic [TICK_W-1:0]         n_tick;
    logic [PERIOD_W-1:0]       n_period;
    logic signed [SUM_W-1:0]   n_lsum;
    logic signed [SUM_W-1:0]   n_rsum;
    logic signed [CORR_W-1:0]  n_u;
    logic signed [DRIVE_W-1:0] n_lhold;
    logic signed [DRIVE_W-1:0] n_rhold;
    logic signed [DRIVE_W-1:0] n_left_drive;
    logic signed [DRIVE_W-1:0] n_right_drive;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_tick < cfg.ticks) begin
            tick_a = r_tick + 1'b1;
            lsum_a = r_lsum + {{(SUM_W-COUNT_W){r_left_count[COUNT_W-1]}}, r_left_count};
            rsum_a = r_rsum + {{(SUM_W-COUNT_W){r_right_count[COUNT_W-1]}}, r_right_count};
        end else begin
            tick_a = r_tick;
            lsum_a = r_lsum;
            rsum_a = r_rsum;
        end
        upd      = tick_a >= cfg.ticks;
        period_a = upd ? r_period + 1'b1 : r_period;
        zero     = period_a >= cfg.periods;

        e_diff  = {rsum_a[SUM_W-1], rsum_a} - {lsum_a[SUM_W-1], lsum_a};
        tgt_x   = $signed({{(WHEEL_ERR_W-TARGET_W){1'b0}}, cfg.target});
        u_x     = {{(WHEEL_ERR_W-CORR_W){r_u[CORR_W-1]}}, r_u};
        e_left  = tgt_x - u_x - {{(WHEEL_ERR_W-SUM_W){lsum_a[SUM_W-1]}}, lsum_a};
        e_right = tgt_x + u_x - {{(WHEEL_ERR_W-SUM_W){rsum_a[SUM_W-1]}}, rsum_a};
    end

    dwcpi_pi_term #(
        .GAIN_W (OUTER_G_W),
        .ERR_W  (DIFF_ERR_W),
        .FRAC_W (OUTER_FRAC),
        .OUT_W  (CORR_W)
    ) u_outer (
        .i_gain_p (cfg.outer_p),
        .i_gain_i (cfg.outer_i),
        .i_window (cfg.window),
        .i_err    (e_diff),
        .o_term   (u_new)
    );

    dwcpi_pi_term #(
        .GAIN_W (INNER_G_W),
        .ERR_W  (WHEEL_ERR_W),
        .FRAC_W (INNER_FRAC),
        .OUT_W  (DRIVE_W)
    ) u_left (
        .i_gain_p (cfg.inner_p),
        .i_gain_i (cfg.inner_i),
        .i_window (cfg.window),
        .i_err    (e_left),
        .o_term   (ldrv_new)
    );

    dwcpi_pi_term #(
        .GAIN_W (INNER_G_W),
        .ERR_W  (WHEEL_ERR_W),
        .FRAC_W (INNER_FRAC),
        .OUT_W  (DRIVE_W)
    ) u_right (
        .i_gain_p (cfg.inner_p),
        .i_gain_i (cfg.inner_i),
        .i_window (cfg.window),
        .i_err    (e_right),
        .o_term   (rdrv_new)
    );

    always_comb begin
        n_tick        = upd ? '0 : tick_a;
        n_lsum        = upd ? '0 : lsum_a;
        n_rsum        = upd ? '0 : rsum_a;
        n_left_drive  = upd ? ldrv_new : r_lhold;
        n_right_drive = upd ? rdrv_new : r_rhold;
        // cycle end: output keeps this tick's drives, state is cleared afterward
        n_period      = zero ? '0 : period_a;
        n_u           = zero ? '0 : (upd ? u_new : r_u);
        n_lhold       = zero ? '0 : n_left_drive;
        n_rhold       = zero ? '0 : n_right_drive;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tick      <= '0;
            r_period    <= '0;
            r_lsum      <= '0;
            r_rsum      <= '0;
            r_u         <= '0;
            r_lhold     <= '0;
            r_rhold     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_tick      <= n_tick;
                r_period    <= n_period;
                r_lsum      <= n_lsum;
                r_rsum      <= n_rsum;
                r_u         <= n_u;
                r_lhold     <= n_lhold;
                r_rhold     <= n_rhold;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_left_count  <= i_left_count;
            r_right_count <= i_right_count;
        end
        if (advance) begin
            r_left_drive  <= n_left_drive;
            r_right_drive <= n_right_drive;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_drive  = r_left_drive;
    assign o_right_drive = r_right_drive;

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked item");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("processed item produced no result");

    a_sums_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && upd) |=> (r_lsum == '0 && r_rsum == '0 && r_tick == '0))
        else $error("period sums not cleared at update");

    a_cycle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && zero) |=> (r_u == '0 && r_lhold == '0 && r_rhold == '0
                               && r_period == '0))
        else $error("cycle end did not zero correction and drives");

    a_drive_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !upd && !zero) |=> (o_left_drive == r_lhold && o_right_drive == r_rhold))
        else $error("result differs from held drives");
`endif

endmodule

/* rtl/dwcpi_cfg_regs.sv */
// Configuration register file for the cascaded PI speed controller.
// Plain write port, no read-back. Depends on dwcpi_pkg.
module dwcpi_cfg_regs
    import dwcpi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inner_p <= RST_INNER_P;
            r_cfg.inner_i <= RST_INNER_I;
            r_cfg.outer_p <= RST_OUTER_P;
            r_cfg.outer_i <= RST_OUTER_I;
            r_cfg.target  <= RST_TARGET;
            r_cfg.window  <= RST_WINDOW;
            r_cfg.ticks   <= RST_TICKS;
            r_cfg.periods <= RST_PERIODS;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_INNER_P: r_cfg.inner_p <= i_cfg_data[INNER_G_W-1:0];
                REG_INNER_I: r_cfg.inner_i <= i_cfg_data[INNER_G_W-1:0];
                REG_OUTER_P: r_cfg.outer_p <= i_cfg_data[OUTER_G_W-1:0];
                REG_OUTER_I: r_cfg.outer_i <= i_cfg_data[OUTER_G_W-1:0];
                REG_TARGET:  r_cfg.target  <= i_cfg_data[TARGET_W-1:0];
                REG_WINDOW:  r_cfg.window  <= i_cfg_data[WINDOW_W-1:0];
                REG_TICKS:   r_cfg.ticks   <= i_cfg_data[TICK_W-1:0];
                REG_PERIODS: r_cfg.periods <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/dwcpi_pi_term.sv */
// One PI term: prop*err + integ*windowed(err), truncated toward zero by 2^FRAC_W, saturated.
// Depends on dwcpi_pkg for the window width.
module dwcpi_pi_term
    import dwcpi_pkg::*;
#(
    parameter int GAIN_W = 20,
    parameter int ERR_W  = 19,
    parameter int FRAC_W = 8,
    parameter int OUT_W  = 24
) (
    input  logic [GAIN_W-1:0]       i_gain_p,
    input  logic [GAIN_W-1:0]       i_gain_i,
    input  logic [WINDOW_W-1:0]     i_window,
    input  logic signed [ERR_W-1:0] i_err,
    output logic signed [OUT_W-1:0] o_term
);

    localparam int PROD_W = GAIN_W + ERR_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int Q_W    = ACC_W - FRAC_W;

    logic [ERR_W-1:0]        mag;
    logic                    in_win;
    logic signed [ERR_W-1:0] err_i;
    logic signed [PROD_W-1:0] prod_p;
    logic signed [PROD_W-1:0] prod_i;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] bias;
    logic signed [ACC_W-1:0] adj;
    logic [Q_W-1:0]          quot;
    logic [Q_W-OUT_W:0]      upper;
    logic                    ovf;

    always_comb begin
        // magnitude of the most negative error still fits as unsigned
        mag    = i_err[ERR_W-1] ? -i_err : i_err;
        in_win = (i_err != '0) && (mag <= {{(ERR_W-WINDOW_W){1'b0}}, i_window});
        err_i  = in_win ? i_err : '0;
        prod_p = $signed({1'b0, i_gain_p}) * i_err;
        prod_i = $signed({1'b0, i_gain_i}) * err_i;
        acc    = $signed({prod_p[PROD_W-1], prod_p}) + $signed({prod_i[PROD_W-1], prod_i});
        // round toward zero: bias negatives before the arithmetic shift
        bias   = acc[ACC_W-1] ? $signed({{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}}) : '0;
        adj    = acc + bias;
        quot   = adj[ACC_W-1:FRAC_W];
        upper  = quot[Q_W-1:OUT_W-1];
        ovf    = !((&upper) || (~|upper));
        if (!ovf) begin
            o_term = $signed(quot[OUT_W-1:0]);
        end else if (quot[Q_W-1]) begin
            o_term = $signed({1'b1, {(OUT_W-1){1'b0}}});
        end else begin
            o_term = $signed({1'b0, {(OUT_W-1){1'b1}}});
        end
    end

endmodule

/* tb/dual_wheel_cascaded_pi_speed_test.sv */
// Self-checking bench for dual_wheel_cascaded_pi_speed: random bursty ticks, stalls and register
// settings, with every drive pair compared against a cycle-free model of the cascaded PI loop.
// Depends on dwcpi_pkg and the dual_wheel_cascaded_pi_speed RTL.
module dual_wheel_cascaded_pi_speed_test;
    import dwcpi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 4;    // output register depth plus margin
    localparam int DRAIN_CYCLES  = 20;
    localparam int QUIET_LIMIT   = 2000; // longest legal quiet stretch is a HOLD_CYCLES receiver hold-off
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_TICKS  = 1750;

    typedef enum logic {OP_TICK, OP_WRITE} t_stim_op;
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;
    typedef enum logic [1:0] {FEED_UNIFORM, FEED_SMALL, FEED_PINNED, FEED_NEAR_TARGET} t_feed;

    typedef struct {
        t_stim_op                  op;
        logic [CFG_IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0]     value;
        logic signed [COUNT_W-1:0] left;
        logic signed [COUNT_W-1:0] right;
    } t_stim;

    typedef struct {
        logic signed [DRIVE_W-1:0] left;
        logic signed [DRIVE_W-1:0] right;
    } t_drive_pair;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic signed [COUNT_W-1:0] i_left_count = '0;
    logic signed [COUNT_W-1:0] i_right_count = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [DRIVE_W-1:0] o_left_drive;
    logic signed [DRIVE_W-1:0] o_right_drive;

    dual_wheel_cascaded_pi_speed i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_left_count  (i_left_count),
        .i_right_count (i_right_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_left_drive  (o_left_drive),
        .o_right_drive (o_right_drive)
    );

    always #10 i_clk = ~i_clk;

    t_stim       stim_q[$];
    t_drive_pair want_q[$];
    int          errors = 0;
    int          ticks_sent = 0;
    int          drives_checked = 0;
    int          writes_done = 0;

    // Controller shadow: registers plus loop state
    t_cfg   regs;
    longint tick_cnt = 0, period_cnt = 0;
    longint left_sum = 0, right_sum = 0, corr = 0;
    longint left_hold = 0, right_hold = 0;

    function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            REG_INNER_P: regs.inner_p = v[INNER_G_W-1:0];
            REG_INNER_I: regs.inner_i = v[INNER_G_W-1:0];
            REG_OUTER_P: regs.outer_p = v[OUTER_G_W-1:0];
            REG_OUTER_I: regs.outer_i = v[OUTER_G_W-1:0];
            REG_TARGET:  regs.target  = v[TARGET_W-1:0];
            REG_WINDOW:  regs.window  = v[WINDOW_W-1:0];
            REG_TICKS:   regs.ticks   = v[TICK_W-1:0];
            REG_PERIODS: regs.periods = v[PERIOD_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic longint saturate(longint v, int w);
        longint hi, lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // integral term only counts for a nonzero error inside the window
    function automatic longint gated(longint e);
        longint mag, win;
        win = regs.window;
        mag = (e < 0) ? -e : e;
        return (e == 0 || mag > win) ? 0 : e;
    endfunction

    function automatic longint wrap_sum(longint v);
        logic signed [SUM_W-1:0] t;
        t = v[SUM_W-1:0];
        return t;
    endfunction

    function automatic t_drive_pair advance(logic signed [COUNT_W-1:0] l,
                                            logic signed [COUNT_W-1:0] r);
        longint tgt, ticks, periods, kip, kii, kop, koi, e, el, er, acc;
        t_drive_pair d;
        tgt = regs.target;
        ticks = regs.ticks;
        periods = regs.periods;
        kip = regs.inner_p;
        kii = regs.inner_i;
        kop = regs.outer_p;
        koi = regs.outer_i;
        if (tick_cnt < ticks) begin
            tick_cnt = (tick_cnt + 1) % 64;
            left_sum = wrap_sum(left_sum + l);
            right_sum = wrap_sum(right_sum + r);
        end
        // >= so that lowering the tick count mid-period still ends the period
        if (tick_cnt >= ticks) begin
            e = right_sum - left_sum;
            el = (tgt - corr) - left_sum;
            er = (tgt + corr) - right_sum;
            tick_cnt = 0;
            period_cnt = (period_cnt + 1) % 256;
            acc = kop * e + koi * gated(e);
            corr = saturate(acc / (longint'(1) << OUTER_FRAC), CORR_W);
            acc = kip * el + kii * gated(el);
            left_hold = saturate(acc / (longint'(1) << INNER_FRAC), DRIVE_W);
            acc = kip * er + kii * gated(er);
            right_hold = saturate(acc / (longint'(1) << INNER_FRAC), DRIVE_W);
            left_sum = 0;
            right_sum = 0;
        end
        d.left = left_hold[DRIVE_W-1:0];
        d.right = right_hold[DRIVE_W-1:0];
        // zeroing happens after this tick's drives are given out
        if (period_cnt >= periods) begin
            corr = 0;
            left_hold = 0;
            right_hold = 0;
            period_cnt = 0;
        end
        return d;
    endfunction

    function automatic void queue_tick(logic signed [COUNT_W-1:0] l,
                                       logic signed [COUNT_W-1:0] r);
        t_stim s;
        s.op = OP_TICK;
        s.idx = '0;
        s.value = '0;
        s.left = l;
        s.right = r;
        stim_q.push_back(s);
    endfunction

    function automatic void queue_write(logic [CFG_IDX_W-1:0] idx, int unsigned v);
        t_stim s;
        s.op = OP_WRITE;
        s.idx = idx;
        s.value = v[CFG_DATA_W-1:0];
        s.left = '0;
        s.right = '0;
        stim_q.push_back(s);
    endfunction

    function automatic int unsigned pick_level(int unsigned max_v, int unsigned rst_v);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return max_v;
            2: return rst_v;
            default: return $urandom_range(0, max_v);
        endcase
    endfunction

    function automatic logic signed [COUNT_W-1:0] pick_pin();
        int v;
        case ($urandom_range(0, 4))
            0: v = -512;
            1: v = 511;
            2: v = -1;
            3: v = 1;
            default: v = 0;
        endcase
        return v[COUNT_W-1:0];
    endfunction

    function automatic logic signed [COUNT_W-1:0] pick_count(t_feed feed,
                                                             logic signed [COUNT_W-1:0] pin);
        int v;
        case (feed)
            FEED_SMALL:       v = int'($urandom_range(0, 8)) - 4;
            FEED_PINNED:      v = ($urandom_range(0, 3) != 0) ? int'(pin)
                                                              : int'($urandom_range(0, 1023));
            FEED_NEAR_TARGET: v = int'($urandom_range(0, 12));
            default:          v = int'($urandom_range(0, 1023));
        endcase
        return v[COUNT_W-1:0];
    endfunction

    function automatic void queue_random_settings();
        if ($urandom_range(0, 1)) queue_write(REG_INNER_P, pick_level(1048575, RST_INNER_P));
        if ($urandom_range(0, 1)) queue_write(REG_INNER_I, pick_level(1048575, RST_INNER_I));
        if ($urandom_range(0, 1)) queue_write(REG_OUTER_P, pick_level(262143, RST_OUTER_P));
        if ($urandom_range(0, 1)) queue_write(REG_OUTER_I, pick_level(262143, RST_OUTER_I));
        if ($urandom_range(0, 1)) queue_write(REG_TARGET, pick_level(1023, RST_TARGET));
        if ($urandom_range(0, 1))
            queue_write(REG_WINDOW, ($urandom_range(0, 2) == 0) ? pick_level(1023, RST_WINDOW)
                                                                : $urandom_range(0, 12));
        if ($urandom_range(0, 3) != 0)
            case ($urandom_range(0, 11))
                0: queue_write(REG_TICKS, 0);
                1, 2: queue_write(REG_TICKS, 63);
                default: queue_write(REG_TICKS, $urandom_range(1, 8));
            endcase
        if ($urandom_range(0, 3) != 0)
            case ($urandom_range(0, 11))
                0: queue_write(REG_PERIODS, 0);
                1: queue_write(REG_PERIODS, 255);
                default: queue_write(REG_PERIODS, $urandom_range(1, 6));
            endcase
    endfunction

    // Sender: bursts of items with gaps; register writes only once all drives are back
    int burst_left = 0, gap_left = 0, settle = 0;

    always @(posedge i_clk) begin : drv
        t_stim                     s;
        logic                      nvalid, nwe;
        logic [CFG_IDX_W-1:0]      naddr;
        logic [CFG_DATA_W-1:0]     ndata;
        logic signed [COUNT_W-1:0] nl, nr;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_cfg_we <= 1'b0;
            burst_left = 0;
            gap_left = 0;
            settle = 0;
        end else begin
            nvalid = i_in_valid;
            nl = i_left_count;
            nr = i_right_count;
            nwe = 1'b0;
            naddr = i_cfg_addr;
            ndata = i_cfg_data;
            if (i_in_valid && !o_in_stall) begin
                want_q.push_back(advance(i_left_count, i_right_count));
                ticks_sent++;
                nvalid = 1'b0;
            end
            settle = (want_q.size() == 0) ? settle + 1 : 0;
            if (!nvalid && stim_q.size() > 0) begin
                if (stim_q[0].op == OP_WRITE) begin
                    if (settle >= SETTLE_CYCLES) begin
                        s = stim_q.pop_front();
                        nwe = 1'b1;
                        naddr = s.idx;
                        ndata = s.value;
                        apply_write(s.idx, s.value);
                        writes_done++;
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    if (gap_left == 0) begin
                        s = stim_q.pop_front();
                        nvalid = 1'b1;
                        nl = s.left;
                        nr = s.right;
                        burst_left--;
                    end
                end
            end
            i_in_valid <= nvalid;
            i_left_count <= nl;
            i_right_count <= nr;
            i_cfg_we <= nwe;
            i_cfg_addr <= naddr;
            i_cfg_data <= ndata;
        end
    end

    // Receiver: stall pattern changes every so often, plus two long hold-offs
    int       rx_cycle = 0, hold_left = 0, mode_left = 0;
    t_rx_mode rx_mode = RX_FREE;

    always @(posedge i_clk) begin : rx
        logic nstall;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle == 1500 || rx_cycle == 3500) hold_left = HOLD_CYCLES;
            if (mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                nstall = 1'b1;
            end else begin
                case (rx_mode)
                    RX_LIGHT:    nstall = ($urandom_range(0, 3) == 0);
                    RX_HEAVY:    nstall = ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: nstall = ((rx_cycle % 8) < 3);
                    default:     nstall = 1'b0;
                endcase
            end
            i_out_stall <= nstall;
        end
    end

    always @(posedge i_clk) begin : mon
        t_drive_pair w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            drives_checked++;
            if (want_q.size() == 0) begin
                $error("unpredicted drive pair: left_drive %0d right_drive %0d",
                       o_left_drive, o_right_drive);
                errors++;
            end else begin
                w = want_q.pop_front();
                if (o_left_drive !== w.left) begin
                    $error("left_drive: expected %0d, got %0d", w.left, o_left_drive);
                    errors++;
                end
                if (o_right_drive !== w.right) begin
                    $error("right_drive: expected %0d, got %0d", w.right, o_right_drive);
                    errors++;
                end
            end
        end
    end

    int quiet = 0;

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n) begin
            quiet = 0;
        end else begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Timeout: nothing moved for %0d cycles, %0d drive pairs outstanding",
                         quiet, want_q.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin : main
        int      n, random_ticks;
        t_feed   lfeed, rfeed;
        logic signed [COUNT_W-1:0] lpin, rpin;
        regs.inner_p = RST_INNER_P;
        regs.inner_i = RST_INNER_I;
        regs.outer_p = RST_OUTER_P;
        regs.outer_i = RST_OUTER_I;
        regs.target  = RST_TARGET;
        regs.window  = RST_WINDOW;
        regs.ticks   = RST_TICKS;
        regs.periods = RST_PERIODS;

        // reset settings: drives must hold at zero mid-period
        queue_tick(511, -512);
        queue_tick(-512, 511);
        queue_tick(0, 0);
        // every gain at full scale, one tick per period: drives saturate
        queue_write(REG_INNER_P, 1048575);
        queue_write(REG_INNER_I, 1048575);
        queue_write(REG_OUTER_P, 262143);
        queue_write(REG_OUTER_I, 262143);
        queue_write(REG_TARGET, 1023);
        queue_write(REG_WINDOW, 1023);
        queue_write(REG_TICKS, 1);
        queue_write(REG_PERIODS, 2);
        queue_tick(511, -512);
        queue_tick(-512, 511);
        queue_tick(0, 0);
        queue_tick(511, 511);
        queue_tick(-512, -512);
        queue_tick(-1, 1);
        // zero tick and period counts: update and zero on every tick with empty sums
        queue_write(REG_INNER_P, 0);
        queue_write(REG_INNER_I, 0);
        queue_write(REG_OUTER_P, 0);
        queue_write(REG_OUTER_I, 0);
        queue_write(REG_TARGET, 0);
        queue_write(REG_WINDOW, 0);
        queue_write(REG_TICKS, 0);
        queue_write(REG_PERIODS, 0);
        queue_tick(5, -5);
        queue_tick(-512, 511);
        // back to nominal gains, then drop the period length below the running tick count
        queue_write(REG_INNER_P, RST_INNER_P);
        queue_write(REG_INNER_I, RST_INNER_I);
        queue_write(REG_OUTER_P, RST_OUTER_P);
        queue_write(REG_OUTER_I, RST_OUTER_I);
        queue_write(REG_TARGET, RST_TARGET);
        queue_write(REG_WINDOW, RST_WINDOW);
        queue_write(REG_TICKS, 10);
        queue_write(REG_PERIODS, RST_PERIODS);
        for (int i = 0; i < 7; i++) queue_tick(COUNT_W'(3 + i % 2), COUNT_W'(4 - i % 3));
        queue_write(REG_TICKS, 3);
        queue_tick(2, 6);

        random_ticks = 0;
        while (random_ticks < RANDOM_TICKS) begin
            queue_random_settings();
            lfeed = t_feed'($urandom_range(0, 3));
            rfeed = ($urandom_range(0, 1)) ? lfeed : t_feed'($urandom_range(0, 3));
            lpin = pick_pin();
            rpin = pick_pin();
            n = $urandom_range(20, 150);
            for (int i = 0; i < n; i++)
                queue_tick(pick_count(lfeed, lpin), pick_count(rfeed, rpin));
            random_ticks += n;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() > 0 || i_in_valid || want_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (want_q.size() != 0) begin
            $error("%0d predicted drive pairs never appeared", want_q.size());
            errors++;
        end

        $display("Covered %0d encoder ticks and %0d register writes; %0d drive pairs compared.",
                 ticks_sent, writes_done, drives_checked);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
